@@ sv/lsq_pkg.sv @@
package lsq_pkg;

    // defaults for the top-level parameters
    localparam int MAX_SEGMENT_POINTS_DEF = 1024;
    localparam int CORDIC_STEPS_DEF       = 16;

    // fixed datapath widths
    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int PT_W      = 17;   // rounded cartesian coordinate
    localparam int SUM_W     = 28;
    localparam int VCNT_W    = 11;
    localparam int CORDIC_W  = 35;   // cordic x and y
    localparam int Z_W       = 33;   // cordic angle accumulator
    localparam int ATAN_W    = 30;
    localparam int ATAN_IX_W = 5;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 64;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [15:0] INV_GAIN = 16'd39797;

    // register reset values
    localparam logic [15:0] NEAR_MM_RST      = 16'd0;
    localparam logic [15:0] FAR_MM_RST       = 16'd65535;
    localparam logic [10:0] MIN_POINTS_RST   = 11'd3;
    localparam logic [10:0] MAX_POINTS_RST   = 11'd50;
    localparam logic [15:0] MIN_DISTANCE_RST = 16'd0;
    localparam logic [15:0] MAX_DISTANCE_RST = 16'd10000;
    localparam logic [15:0] MIN_WIDTH_RST    = 16'd0;

    typedef struct packed {
        logic [RANGE_W-1:0]        range_mm;
        logic signed [ANGLE_W-1:0] beam_angle;
        logic                      last_of_segment;
    } t_in_item;

    typedef struct packed {
        logic              segment_accepted;
        logic [1:0]        reject_reason;
        logic [VCNT_W-1:0] valid_points;
    } t_out_item;

    typedef struct packed {
        logic                   done;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } t_cordic_res;

    typedef enum logic [1:0] {
        REASON_NONE  = 2'd0,
        REASON_COUNT = 2'd1,
        REASON_DIST  = 2'd2,
        REASON_WIDTH = 2'd3
    } t_reason;

    typedef enum logic [2:0] {
        REG_NEAR_MM      = 3'd0,
        REG_FAR_MM       = 3'd1,
        REG_MIN_POINTS   = 3'd2,
        REG_MAX_POINTS   = 3'd3,
        REG_MIN_DISTANCE = 3'd4,
        REG_MAX_DISTANCE = 3'd5,
        REG_MIN_WIDTH    = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_ACCUM,
        ST_COUNT,
        ST_SQ_Y,
        ST_LO,
        ST_LO_SQ,
        ST_HI,
        ST_HI_SQ,
        ST_DIST,
        ST_DX,
        ST_DY,
        ST_WSQ,
        ST_WCMP,
        ST_OUT
    } t_state;

    // atan(2^-i) with 2^31 standing for pi
    function automatic logic [ATAN_W-1:0] atan_val(input logic [ATAN_IX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round to nearest in 16 fraction bits, clamp to the coordinate range
    function automatic logic signed [PT_W-1:0] round_sat(input logic signed [CORDIC_W:0] v);
        logic signed [CORDIC_W+1:0] t;
        logic signed [20:0]         q;
        logic signed [PT_W-1:0]     r;
        t = {v[CORDIC_W], v} + (CORDIC_W+2)'(32768);
        q = 21'(t >>> 16);
        if (q > 21'sd65535) begin
            r = 17'sd65535;
        end else if (q < -21'sd65536) begin
            r = -17'sd65536;
        end else begin
            r = q[PT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/laser_segment_qualifier.sv @@
// Qualifies laser segments point by point. Each point transfer carries a range
// in mm, a binary beam angle (32768 = pi) and a last-of-segment flag; points
// inside the near and far range limits are converted to x/y by an iterative
// CORDIC and summed. The last point of a segment yields one verdict transfer:
// rejected for point count, mean distance or width (checked in that order) or
// accepted, with the saturated valid-point count. An in-range point goes through
// the iterative CORDIC loop, one rotation per cycle, before it is summed; an
// out-of-range point skips the loop. The input stalls until a point is through.
// The last point of a segment also runs the verdict, whose squares all go through
// one shared registered multiplier, and waits if the previous verdict is stalled.
// Registers sit at byte offsets 4*index on the APB port; pready is always high.
module laser_segment_qualifier #(
    parameter int MAX_SEGMENT_POINTS = lsq_pkg::MAX_SEGMENT_POINTS_DEF,
    parameter int CORDIC_STEPS       = lsq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lsq_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lsq_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsq_pkg::APB_AW-1:0]    paddr,
    input  logic [lsq_pkg::APB_DW-1:0]    pwdata,
    output logic [lsq_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int CNT_W = $clog2(MAX_SEGMENT_POINTS + 1);
    localparam int CMP_W = (CNT_W > lsq_pkg::VCNT_W) ? CNT_W : lsq_pkg::VCNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENT_POINTS);
    localparam int MW = lsq_pkg::MUL_W;
    localparam int PW = lsq_pkg::PT_W;
    localparam int SUMW = lsq_pkg::SUM_W;

    // configuration
    logic [15:0] r_near_mm;
    logic [15:0] r_far_mm;
    logic [10:0] r_min_points;
    logic [10:0] r_max_points;
    logic [15:0] r_min_distance;
    logic [15:0] r_max_distance;
    logic [15:0] r_min_width;

    lsq_pkg::t_state  r_state;
    lsq_pkg::t_state  n_state;
    lsq_pkg::t_reason r_reason;
    lsq_pkg::t_reg_idx reg_idx;

    // segment state
    logic [SUMW-1:0]      r_sum_x;
    logic [SUMW-1:0]      r_sum_y;
    logic [CNT_W-1:0]     r_count;
    logic signed [PW-1:0] r_first_x;
    logic signed [PW-1:0] r_first_y;
    logic                 r_first_valid;
    logic                 r_open;

    // current point
    logic                 r_cur_valid;
    logic                 r_last;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;

    logic [lsq_pkg::PROD_W-1:0] r_s;
    logic [lsq_pkg::PROD_W-1:0] r_lo2;

    logic                 r_out_valid;
    lsq_pkg::t_out_item   r_out;

    logic                 in_xfer;
    logic                 in_range;
    logic                 cordic_start;
    logic                 count_fail;
    logic                 dist_fail;
    logic                 skip_width;
    logic                 out_free;
    logic                 cfg_wr;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic [lsq_pkg::PROD_W-1:0] mul_p;
    logic signed [PW:0]   dx;
    logic signed [PW:0]   dy;
    lsq_pkg::t_cordic_res cres;

    lsq_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_range (i_in_data.range_mm),
        .i_angle (i_in_data.beam_angle),
        .o_res   (cres)
    );

    lsq_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign in_range = (i_in_data.range_mm >= r_near_mm) &&
                      (i_in_data.range_mm <= r_far_mm);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign reg_idx  = lsq_pkg::t_reg_idx'(paddr[4:2]);

    assign count_fail = (CMP_W'(r_count) < CMP_W'(r_min_points)) ||
                        (CMP_W'(r_count) > CMP_W'(r_max_points));
    assign dist_fail  = (r_count != '0) && ((r_s < r_lo2) || (r_s > mul_p));
    assign skip_width = (r_min_width == 16'd0) || !r_first_valid || !r_cur_valid;

    assign dx = {r_px[PW-1], r_px} - {r_first_x[PW-1], r_first_x};
    assign dy = {r_py[PW-1], r_py} - {r_first_y[PW-1], r_first_y};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsq_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = in_range ? lsq_pkg::ST_CORDIC : lsq_pkg::ST_ACCUM;
                end
            end
            lsq_pkg::ST_CORDIC: begin
                if (cres.done) begin
                    n_state = lsq_pkg::ST_ACCUM;
                end
            end
            lsq_pkg::ST_ACCUM: n_state = r_last ? lsq_pkg::ST_COUNT : lsq_pkg::ST_IDLE;
            lsq_pkg::ST_COUNT: n_state = count_fail ? lsq_pkg::ST_OUT : lsq_pkg::ST_SQ_Y;
            lsq_pkg::ST_SQ_Y:  n_state = lsq_pkg::ST_LO;
            lsq_pkg::ST_LO:    n_state = lsq_pkg::ST_LO_SQ;
            lsq_pkg::ST_LO_SQ: n_state = lsq_pkg::ST_HI;
            lsq_pkg::ST_HI:    n_state = lsq_pkg::ST_HI_SQ;
            lsq_pkg::ST_HI_SQ: n_state = lsq_pkg::ST_DIST;
            lsq_pkg::ST_DIST: begin
                n_state = (dist_fail || skip_width) ? lsq_pkg::ST_OUT : lsq_pkg::ST_DX;
            end
            lsq_pkg::ST_DX:    n_state = lsq_pkg::ST_DY;
            lsq_pkg::ST_DY:    n_state = lsq_pkg::ST_WSQ;
            lsq_pkg::ST_WSQ:   n_state = lsq_pkg::ST_WCMP;
            lsq_pkg::ST_WCMP:  n_state = lsq_pkg::ST_OUT;
            lsq_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = lsq_pkg::ST_IDLE;
                end
            end
            default: n_state = lsq_pkg::ST_IDLE;
        endcase
    end

    // control and multiplier operands
    always_comb begin
        o_in_stall   = (r_state != lsq_pkg::ST_IDLE);
        cordic_start = (r_state == lsq_pkg::ST_IDLE) && in_xfer && in_range;
        mul_a        = '0;
        mul_b        = '0;
        unique case (r_state) inside
            lsq_pkg::ST_COUNT: begin
                mul_a = {{(MW - SUMW){r_sum_x[SUMW-1]}}, r_sum_x};
                mul_b = mul_a;
            end
            lsq_pkg::ST_SQ_Y: begin
                mul_a = {{(MW - SUMW){r_sum_y[SUMW-1]}}, r_sum_y};
                mul_b = mul_a;
            end
            lsq_pkg::ST_LO: begin
                mul_a = MW'(r_min_distance);
                mul_b = MW'(r_count);
            end
            lsq_pkg::ST_LO_SQ, lsq_pkg::ST_HI_SQ: begin
                mul_a = mul_p[MW-1:0];
                mul_b = mul_p[MW-1:0];
            end
            lsq_pkg::ST_HI: begin
                mul_a = MW'(r_max_distance);
                mul_b = MW'(r_count);
            end
            lsq_pkg::ST_DX: begin
                mul_a = {{(MW - PW - 1){dx[PW]}}, dx};
                mul_b = mul_a;
            end
            lsq_pkg::ST_DY: begin
                mul_a = {{(MW - PW - 1){dy[PW]}}, dy};
                mul_b = mul_a;
            end
            lsq_pkg::ST_WSQ: begin
                mul_a = MW'(r_min_width);
                mul_b = MW'(r_min_width);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // segment accumulation and verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x       <= '0;
            r_sum_y       <= '0;
            r_count       <= '0;
            r_first_x     <= '0;
            r_first_y     <= '0;
            r_first_valid <= 1'b0;
            r_open        <= 1'b0;
            r_cur_valid   <= 1'b0;
            r_last        <= 1'b0;
            r_reason      <= lsq_pkg::REASON_NONE;
        end else begin
            unique case (r_state)
                lsq_pkg::ST_IDLE: begin
                    if (in_xfer) begin
                        r_cur_valid <= in_range;
                        r_last      <= i_in_data.last_of_segment;
                        r_px        <= '0;
                        r_py        <= '0;
                    end
                end
                lsq_pkg::ST_CORDIC: begin
                    if (cres.done) begin
                        r_px <= cres.x;
                        r_py <= cres.y;
                    end
                end
                lsq_pkg::ST_ACCUM: begin
                    if (!r_open) begin
                        r_open        <= 1'b1;
                        r_first_valid <= r_cur_valid;
                        r_first_x     <= r_px;
                        r_first_y     <= r_py;
                    end
                    // count stops at its bound, later points stay out of the sums
                    if (r_cur_valid && (r_count < MAX_CNT)) begin
                        r_sum_x <= r_sum_x + {{(SUMW - PW){r_px[PW-1]}}, r_px};
                        r_sum_y <= r_sum_y + {{(SUMW - PW){r_py[PW-1]}}, r_py};
                        r_count <= r_count + 1'b1;
                    end
                end
                lsq_pkg::ST_COUNT: begin
                    r_reason <= count_fail ? lsq_pkg::REASON_COUNT : lsq_pkg::REASON_NONE;
                end
                lsq_pkg::ST_SQ_Y: r_s <= mul_p;
                lsq_pkg::ST_LO:   r_s <= r_s + mul_p;
                lsq_pkg::ST_HI:   r_lo2 <= mul_p;
                lsq_pkg::ST_DIST: begin
                    if (dist_fail) begin
                        r_reason <= lsq_pkg::REASON_DIST;
                    end
                end
                lsq_pkg::ST_DY:   r_s <= mul_p;
                lsq_pkg::ST_WSQ:  r_s <= r_s + mul_p;
                lsq_pkg::ST_WCMP: begin
                    if (r_s < mul_p) begin
                        r_reason <= lsq_pkg::REASON_WIDTH;
                    end
                end
                lsq_pkg::ST_OUT: begin
                    if (out_free) begin
                        r_sum_x       <= '0;
                        r_sum_y       <= '0;
                        r_count       <= '0;
                        r_first_x     <= '0;
                        r_first_y     <= '0;
                        r_first_valid <= 1'b0;
                        r_open        <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register, loaded when empty or while the previous result is being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lsq_pkg::ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lsq_pkg::ST_OUT && out_free) begin
            r_out.segment_accepted <= (r_reason == lsq_pkg::REASON_NONE);
            r_out.reject_reason    <= r_reason;
            r_out.valid_points     <= lsq_pkg::VCNT_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_mm      <= lsq_pkg::NEAR_MM_RST;
            r_far_mm       <= lsq_pkg::FAR_MM_RST;
            r_min_points   <= lsq_pkg::MIN_POINTS_RST;
            r_max_points   <= lsq_pkg::MAX_POINTS_RST;
            r_min_distance <= lsq_pkg::MIN_DISTANCE_RST;
            r_max_distance <= lsq_pkg::MAX_DISTANCE_RST;
            r_min_width    <= lsq_pkg::MIN_WIDTH_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                lsq_pkg::REG_NEAR_MM:      r_near_mm      <= pwdata[15:0];
                lsq_pkg::REG_FAR_MM:       r_far_mm       <= pwdata[15:0];
                lsq_pkg::REG_MIN_POINTS:   r_min_points   <= pwdata[10:0];
                lsq_pkg::REG_MAX_POINTS:   r_max_points   <= pwdata[10:0];
                lsq_pkg::REG_MIN_DISTANCE: r_min_distance <= pwdata[15:0];
                lsq_pkg::REG_MAX_DISTANCE: r_max_distance <= pwdata[15:0];
                lsq_pkg::REG_MIN_WIDTH:    r_min_width    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lsq_pkg::REG_NEAR_MM:      prdata = lsq_pkg::APB_DW'(r_near_mm);
            lsq_pkg::REG_FAR_MM:       prdata = lsq_pkg::APB_DW'(r_far_mm);
            lsq_pkg::REG_MIN_POINTS:   prdata = lsq_pkg::APB_DW'(r_min_points);
            lsq_pkg::REG_MAX_POINTS:   prdata = lsq_pkg::APB_DW'(r_max_points);
            lsq_pkg::REG_MIN_DISTANCE: prdata = lsq_pkg::APB_DW'(r_min_distance);
            lsq_pkg::REG_MAX_DISTANCE: prdata = lsq_pkg::APB_DW'(r_max_distance);
            lsq_pkg::REG_MIN_WIDTH:    prdata = lsq_pkg::APB_DW'(r_min_width);
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

@@ sv/lsq_mul.sv @@
module lsq_mul (
    input  logic                               i_clk,
    input  logic signed [lsq_pkg::MUL_W-1:0]   i_a,
    input  logic signed [lsq_pkg::MUL_W-1:0]   i_b,
    output logic        [lsq_pkg::PROD_W-1:0]  o_p
);

    logic signed [2*lsq_pkg::MUL_W-1:0] full;
    logic        [lsq_pkg::PROD_W-1:0]  r_p;

    assign full = i_a * i_b;

    // product wraps at 64 bits
    always_ff @(posedge i_clk) begin
        r_p <= full[lsq_pkg::PROD_W-1:0];
    end

    assign o_p = r_p;

endmodule

@@ sv/lsq_cordic.sv @@
module lsq_cordic #(
    parameter int CORDIC_STEPS = lsq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic        [lsq_pkg::RANGE_W-1:0]   i_range,
    input  logic signed [lsq_pkg::ANGLE_W-1:0]   i_angle,
    output lsq_pkg::t_cordic_res                 o_res
);

    localparam int CW = lsq_pkg::CORDIC_W;
    localparam int ZW = lsq_pkg::Z_W;
    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [SW-1:0]        r_step;
    logic                 r_flip;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [16:0]   ang_w;
    logic signed [16:0]   fold_w;
    logic                 fold_flip;
    logic [31:0]          x0_prod;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [ZW-1:0] atan_z;
    logic signed [CW:0]   vx;
    logic signed [CW:0]   vy;

    // fold the angle into the right half plane
    always_comb begin
        ang_w     = {i_angle[15], i_angle};
        fold_w    = ang_w;
        fold_flip = 1'b0;
        if (ang_w >= 17'sd16384) begin
            fold_w    = ang_w - 17'sd32768;
            fold_flip = 1'b1;
        end else if (ang_w < -17'sd16384) begin
            fold_w    = ang_w + 17'sd32768;
            fold_flip = 1'b1;
        end
    end

    assign x0_prod = i_range * lsq_pkg::INV_GAIN;
    assign sx      = r_x >>> r_step;
    assign sy      = r_y >>> r_step;
    assign atan_z  = {{(ZW - lsq_pkg::ATAN_W){1'b0}},
                      lsq_pkg::atan_val(lsq_pkg::ATAN_IX_W'(r_step))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= {{(CW - 32){1'b0}}, x0_prod};
            r_y    <= '0;
            r_z    <= {fold_w[ZW-17:0], 16'b0};
            r_flip <= fold_flip;
        end else if (r_busy) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - atan_z;
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + atan_z;
            end
        end
    end

    // y of the sensor frame is the negated rotation result
    always_comb begin
        vx = {r_x[CW-1], r_x};
        vy = {r_y[CW-1], r_y};
        if (r_flip) begin
            vx = -vx;
        end else begin
            vy = -vy;
        end
        o_res.done = r_done;
        o_res.x    = lsq_pkg::round_sat(vx);
        o_res.y    = lsq_pkg::round_sat(vy);
    end

endmodule

@@ sim/laser_segment_qualifier_tb.sv @@
module laser_segment_qualifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int SETTLE_CYCLES = 64;     // cordic + verdict, with margin
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 60;
    localparam int IDLE_PCT      = 26;
    localparam int SAT_POINTS    = lsq_pkg::MAX_SEGMENT_POINTS_DEF + 6;

    logic                       i_clk    = 1'b0;
    logic                       i_rst_n  = 1'b0;
    logic                       pt_valid = 1'b0;
    logic                       pt_stall;
    lsq_pkg::t_in_item          pt_item  = '0;
    logic                       vd_valid;
    logic                       vd_stall = 1'b0;
    lsq_pkg::t_out_item         vd_item;
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [lsq_pkg::APB_AW-1:0] paddr    = '0;
    logic [lsq_pkg::APB_DW-1:0] pwdata   = '0;
    logic [lsq_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    laser_segment_qualifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (pt_valid),
        .o_in_stall  (pt_stall),
        .i_in_data   (pt_item),
        .o_out_valid (vd_valid),
        .i_out_stall (vd_stall),
        .o_out_data  (vd_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    lsq_pkg::t_in_item  point_q[$];
    lsq_pkg::t_out_item verdict_q[$];
    int                 points_queued = 0;
    int                 verdicts_seen = 0;
    int                 mismatches    = 0;
    bit                 calm          = 1'b0;

    // register shadow
    int unsigned cfg_near_mm      = lsq_pkg::NEAR_MM_RST;
    int unsigned cfg_far_mm       = lsq_pkg::FAR_MM_RST;
    int unsigned cfg_min_points   = lsq_pkg::MIN_POINTS_RST;
    int unsigned cfg_max_points   = lsq_pkg::MAX_POINTS_RST;
    int unsigned cfg_min_distance = lsq_pkg::MIN_DISTANCE_RST;
    int unsigned cfg_max_distance = lsq_pkg::MAX_DISTANCE_RST;
    int unsigned cfg_min_width    = lsq_pkg::MIN_WIDTH_RST;

    // open segment
    logic [lsq_pkg::SUM_W-1:0] seg_sum_x   = '0;
    logic [lsq_pkg::SUM_W-1:0] seg_sum_y   = '0;
    int                        seg_count   = 0;
    longint                    seg_first_x = 0;
    longint                    seg_first_y = 0;
    bit                        seg_first_ok = 1'b0;
    bit                        seg_open    = 1'b0;

    // atan(2^-i), 2^31 is pi
    longint atan_units [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    function automatic longint coord_round(input longint v);
        longint q;
        q = (v + 32768) >>> 16;
        if (q > 65535) q = 65535;
        if (q < -65536) q = -65536;
        return q;
    endfunction

    function automatic void polar_to_xy(input int unsigned r, input int ang,
                                        output longint px, output longint py);
        longint cx, cy, z, nx;
        bit     flip;
        int     i;
        flip = 1'b0;
        // fold the rear half-plane onto the front one
        if (ang >= 16384) begin
            ang -= 32768;
            flip = 1'b1;
        end else if (ang < -16384) begin
            ang += 32768;
            flip = 1'b1;
        end
        z  = longint'(ang) * 65536;
        cx = longint'(r) * longint'(lsq_pkg::INV_GAIN);
        cy = 0;
        for (i = 0; i < lsq_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
            if (z >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z  = z - atan_units[i];
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z  = z + atan_units[i];
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        px = coord_round(cx);
        py = coord_round(-cy);
    endfunction

    // fold one accepted point into the segment; queue a verdict on the closing point
    function automatic void qualify_point(input lsq_pkg::t_in_item it);
        int unsigned        r;
        int                 ang;
        bit                 ok;
        longint             px, py, sx, sy, dx, dy, s, lo, hi, d2;
        lsq_pkg::t_reason   why;
        lsq_pkg::t_out_item v;
        r   = it.range_mm;
        ang = $signed(it.beam_angle);
        ok  = (r >= cfg_near_mm) && (r <= cfg_far_mm);
        px  = 0;
        py  = 0;
        why = lsq_pkg::REASON_NONE;
        if (ok) polar_to_xy(r, ang, px, py);
        if (!seg_open) begin
            seg_open     = 1'b1;
            seg_first_ok = ok;
            seg_first_x  = px;
            seg_first_y  = py;
        end
        if (ok && seg_count < lsq_pkg::MAX_SEGMENT_POINTS_DEF) begin
            seg_sum_x = seg_sum_x + lsq_pkg::SUM_W'(px);
            seg_sum_y = seg_sum_y + lsq_pkg::SUM_W'(py);
            seg_count++;
        end
        if (!it.last_of_segment) return;

        if (seg_count < cfg_min_points || seg_count > cfg_max_points) begin
            why = lsq_pkg::REASON_COUNT;
        end else begin
            // no valid point: the distance test passes
            if (seg_count > 0) begin
                sx = $signed(seg_sum_x);
                sy = $signed(seg_sum_y);
                s  = sx * sx + sy * sy;
                lo = longint'(cfg_min_distance) * seg_count;
                hi = longint'(cfg_max_distance) * seg_count;
                if (s < lo * lo || s > hi * hi) why = lsq_pkg::REASON_DIST;
            end
            if (why == lsq_pkg::REASON_NONE && cfg_min_width > 0 && seg_first_ok && ok) begin
                dx = px - seg_first_x;
                dy = py - seg_first_y;
                d2 = dx * dx + dy * dy;
                if (d2 < longint'(cfg_min_width) * cfg_min_width)
                    why = lsq_pkg::REASON_WIDTH;
            end
        end
        v.segment_accepted = (why == lsq_pkg::REASON_NONE);
        v.reject_reason    = why;
        v.valid_points     = lsq_pkg::VCNT_W'(seg_count);
        verdict_q = {verdict_q, v};

        seg_sum_x    = '0;
        seg_sum_y    = '0;
        seg_count    = 0;
        seg_first_x  = 0;
        seg_first_y  = 0;
        seg_first_ok = 1'b0;
        seg_open     = 1'b0;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // point sender
    always @(posedge i_clk) begin : point_driver
        bit give;
        if (!i_rst_n) begin
            pt_valid <= 1'b0;
        end else begin
            if (pt_valid && !pt_stall) begin
                qualify_point(pt_item);
                point_q.delete(0);
            end
            if (!pt_valid || !pt_stall) begin
                give = point_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT);
                pt_valid <= give;
                if (give) pt_item <= point_q[0];
            end
        end
    end

    // verdict receiver stall, with one long hold-off
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin : verdict_stall
        if (!i_rst_n) begin
            vd_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            vd_stall  <= 1'b1;
        end else if (!hold_done && verdicts_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            vd_stall  <= 1'b1;
        end else begin
            vd_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : verdict_monitor
        lsq_pkg::t_out_item want;
        if (i_rst_n && vd_valid && !vd_stall) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                flag_mismatch($sformatf("verdict %0d with no segment closed (acc %b rsn %0d n %0d)",
                    verdicts_seen, vd_item.segment_accepted, vd_item.reject_reason,
                    vd_item.valid_points));
            end else begin
                want = verdict_q.pop_front();
                if (vd_item.segment_accepted !== want.segment_accepted)
                    flag_mismatch($sformatf("verdict %0d segment_accepted %b, expected %b",
                        verdicts_seen, vd_item.segment_accepted, want.segment_accepted));
                if (vd_item.reject_reason !== want.reject_reason)
                    flag_mismatch($sformatf("verdict %0d reject_reason %0d, expected %0d",
                        verdicts_seen, vd_item.reject_reason, want.reject_reason));
                if (vd_item.valid_points !== want.valid_points)
                    flag_mismatch($sformatf("verdict %0d valid_points %0d, expected %0d",
                        verdicts_seen, vd_item.valid_points, want.valid_points));
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (pt_valid && !pt_stall) || (vd_valid && !vd_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("laser_segment_qualifier verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_reg(input lsq_pkg::t_reg_idx idx, input int unsigned val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            lsq_pkg::REG_NEAR_MM:      cfg_near_mm      = val & 32'hFFFF;
            lsq_pkg::REG_FAR_MM:       cfg_far_mm       = val & 32'hFFFF;
            lsq_pkg::REG_MIN_POINTS:   cfg_min_points   = val & 32'h7FF;
            lsq_pkg::REG_MAX_POINTS:   cfg_max_points   = val & 32'h7FF;
            lsq_pkg::REG_MIN_DISTANCE: cfg_min_distance = val & 32'hFFFF;
            lsq_pkg::REG_MAX_DISTANCE: cfg_max_distance = val & 32'hFFFF;
            lsq_pkg::REG_MIN_WIDTH:    cfg_min_width    = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic load_config(input int unsigned rmin, input int unsigned rmax,
                               input int unsigned minp, input int unsigned maxp,
                               input int unsigned mind, input int unsigned maxd,
                               input int unsigned wid);
        set_reg(lsq_pkg::REG_NEAR_MM, rmin);
        set_reg(lsq_pkg::REG_FAR_MM, rmax);
        set_reg(lsq_pkg::REG_MIN_POINTS, minp);
        set_reg(lsq_pkg::REG_MAX_POINTS, maxp);
        set_reg(lsq_pkg::REG_MIN_DISTANCE, mind);
        set_reg(lsq_pkg::REG_MAX_DISTANCE, maxd);
        set_reg(lsq_pkg::REG_MIN_WIDTH, wid);
    endtask

    task automatic add_point(input int r, input int a, input bit closing);
        lsq_pkg::t_in_item it;
        it.range_mm        = lsq_pkg::RANGE_W'(r);
        it.beam_angle      = lsq_pkg::ANGLE_W'(a);
        it.last_of_segment = closing;
        point_q = {point_q, it};
        points_queued++;
    endtask

    // a sweep of neighboring beams around one range, with some noise
    task automatic add_segment(input int r0);
        int len, ang, step, r, a, i;
        bit closing;
        len  = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
        ang  = $urandom_range(65535);
        step = $urandom_range(400, 20);
        if ($urandom_range(1)) step = -step;
        for (i = 0; i < len; i++) begin
            a = ang;
            case ($urandom_range(19)) inside
                0, 1: begin
                    r = $urandom_range(65535);
                    a = $urandom_range(65535);
                end
                2:       r = 0;
                3:       r = 65535;
                default: r = r0 + $urandom_range(400) - 200;
            endcase
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
            // an early closing flag now and then breaks the sweep
            closing = (i == len - 1) || ($urandom_range(49) == 0);
            add_point(r, a, closing);
            ang += step;
        end
    endtask

    task automatic drain();
        while (point_q.size() != 0 || pt_valid || verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          k, budget, i;
        int unsigned start, rmin, rmax, minp, maxp, mind, maxd, wid;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: angle extremes, quadrant fold edges, range extremes
        add_point(0, 0, 1'b0);
        add_point(65535, 16384, 1'b0);
        add_point(2000, -16384, 1'b1);
        add_point(3000, -32768, 1'b0);
        add_point(3000, 32767, 1'b0);
        add_point(3000, 16383, 1'b0);
        add_point(3000, -16385, 1'b1);
        add_point(500, 8192, 1'b1);
        add_point(65535, -8192, 1'b0);
        add_point(65535, 0, 1'b0);
        add_point(65535, 100, 1'b1);
        drain();

        // narrow range window with the width test on
        load_config(1000, 2000, 0, 1024, 0, 65535, 50);
        add_point(0, 0, 1'b0);
        add_point(65535, 0, 1'b1);         // no valid point
        add_point(1500, 4000, 1'b1);       // one point spans nothing
        add_point(500, 0, 1'b0);
        add_point(1500, 0, 1'b1);          // first point out of range
        add_point(1500, 0, 1'b0);
        add_point(2500, 0, 1'b1);          // last point out of range
        add_point(1000, 0, 1'b0);
        add_point(2000, 16384, 1'b1);
        add_point(1500, 0, 1'b0);
        add_point(1510, 0, 1'b1);
        drain();

        // inverted range window
        load_config(40000, 39999, 0, 1024, 0, 65535, 65535);
        add_point(39999, 0, 1'b0);
        add_point(40000, 0, 1'b1);
        add_point(50000, 0, 1'b1);
        drain();

        for (k = 0; k < 8; k++) begin
            calm = (k == 5);
            if (k == 0) begin
                load_config(0, 0, 0, 0, 0, 0, 0);
            end else if (k == 1) begin
                load_config(65535, 65535, 1024, 1024, 65535, 65535, 65535);
            end else begin
                rmin = ($urandom_range(3) == 0) ? 0 : $urandom_range(1500);
                rmax = ($urandom_range(3) == 0) ? 65535 : $urandom_range(40000, 6000);
                minp = $urandom_range(5);
                maxp = $urandom_range(40, 3);
                mind = $urandom_range(2500);
                maxd = mind + $urandom_range(14000, 500);
                wid  = ($urandom_range(2) == 0) ? 0 : $urandom_range(2500, 1);
                load_config(rmin, rmax, minp, maxp, mind, maxd, wid);
            end
            budget = (k < 2) ? 60 : 110;
            start  = points_queued;
            while (points_queued - start < budget) begin
                add_segment((k < 2) ? $urandom_range(65535) : $urandom_range(12000, 200));
            end
            drain();
        end

        // one segment long enough to saturate the point count
        calm = 1'b0;
        load_config(0, 65535, 0, 1024, 0, 65535, 1);
        for (i = 0; i < SAT_POINTS; i++) begin
            add_point($urandom_range(3000, 100), $urandom_range(65535), i == SAT_POINTS - 1);
        end
        drain();

        if (verdict_q.size() != 0) flag_mismatch("segments left without a verdict");
        if (mismatches == 0) begin
            $display("laser_segment_qualifier verification clean");
        end else begin
            $display("laser_segment_qualifier verification failed");
        end
        $finish;
    end

endmodule
